/* rtl/edrf_pkg.sv */
// shared constants and helpers for the escape decoding receive fifo
`timescale 1ns / 1ps
`default_nettype none
package edrf_pkg;

  // ring geometry
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FILL_W     = PTR_W + 1;
  localparam int unsigned SAT_W      = (FILL_W > 8) ? FILL_W : 8;

  // byte and configuration widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_VALUE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNESCAPE_MASK = 1'd1;

  // configuration reset values
  localparam logic [BYTE_W-1:0] ESCAPE_VALUE_RST  = 8'd125;
  localparam logic [BYTE_W-1:0] UNESCAPE_MASK_RST = 8'd32;

  // item kinds
  localparam logic FUNC_LINE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;

  // advance a ring pointer with wrap at the ring depth
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // bytes held between read and write pointers, saturated to eight bits
  function automatic logic [7:0] ring_fill(input ptr_t wp, input ptr_t rp);
    logic [FILL_W-1:0] f;
    logic [SAT_W-1:0]  ext;
    if (wp >= rp) begin
      f = FILL_W'(wp) - FILL_W'(rp);
    end else begin
      f = FILL_W'(RING_DEPTH) - (FILL_W'(rp) - FILL_W'(wp));
    end
    ext = SAT_W'(f);
    return (ext > SAT_W'(255)) ? 8'hFF : ext[7:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/edrf_if.sv */
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps
`default_nettype none
interface edrf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] line_byte;

  modport source (output valid, output func, output line_byte, input ready);
  modport sink   (input valid, input func, input line_byte, output ready);
endinterface

interface edrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [7:0] fill_count;
  logic       oldest_dropped;
  logic       byte_stored;

  modport source (output valid, output read_data, output read_valid, output fill_count,
                  output oldest_dropped, output byte_stored, input ready);
  modport sink   (input valid, input read_data, input read_valid, input fill_count,
                  input oldest_dropped, input byte_stored, output ready);
endinterface
`default_nettype wire

/* rtl/edrf_ram.sv */
// simple dual port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module edrf_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/escape_decoding_rx_fifo.sv */
// Result: the result of an item is registered and presented the cycle after its transfer.
// Throughput: one item per cycle while out_o.ready stays high, set by the single write and
//   single read port of the ring memory, each used at most once per item.
// Reset: pointers, escape flag and output valid clear at once; escape value 125 and
//   mask 32 restore; ring contents stay undefined and are never read before written.
`timescale 1ns / 1ps
`default_nettype none
module escape_decoding_rx_fifo (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [edrf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [edrf_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  edrf_in_if.sink                              in_i,
  edrf_out_if.source                           out_o
);
  import edrf_pkg::*;

  logic [BYTE_W-1:0] esc_val_q, esc_mask_q;
  ptr_t              wr_ptr_q, wr_ptr_d;
  ptr_t              rd_ptr_q, rd_ptr_d;
  logic              esc_pend_q, esc_pend_d;
  logic              out_valid_q;
  logic              rvalid_q, rvalid_d;
  logic [7:0]        fill_q, fill_d;
  logic              dropped_q, dropped_d;
  logic              stored_q, stored_d;
  logic              in_xfer;
  logic              ring_empty;
  logic              mem_we, mem_re;
  logic [BYTE_W-1:0] wr_byte;
  logic [BYTE_W-1:0] mem_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_val_q  <= ESCAPE_VALUE_RST;
      esc_mask_q <= UNESCAPE_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ESCAPE_VALUE:  esc_val_q  <= cfg_data_i;
        CFG_UNESCAPE_MASK: esc_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake: take an item whenever the result slot frees up
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign ring_empty = (wr_ptr_q == rd_ptr_q);

  // unstuffing, pointer update and result flags
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    esc_pend_d = esc_pend_q;
    rvalid_d   = 1'b0;
    dropped_d  = 1'b0;
    stored_d   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    wr_byte    = in_i.line_byte;
    if (in_xfer) begin
      if (in_i.func == FUNC_READ) begin
        if (!ring_empty) begin
          mem_re   = 1'b1;
          rvalid_d = 1'b1;
          rd_ptr_d = ptr_next(rd_ptr_q);
        end
      end else begin
        if (esc_pend_q) begin
          wr_byte    = in_i.line_byte ^ esc_mask_q;
          esc_pend_d = 1'b0;
          mem_we     = 1'b1;
        end else if (in_i.line_byte == esc_val_q) begin
          esc_pend_d = 1'b1;
        end else begin
          mem_we = 1'b1;
        end
        if (mem_we) begin
          stored_d = 1'b1;
          wr_ptr_d = ptr_next(wr_ptr_q);
          if (ptr_next(wr_ptr_q) == rd_ptr_q) begin
            rd_ptr_d  = ptr_next(rd_ptr_q);
            dropped_d = 1'b1;
          end
        end
      end
    end
    fill_d = ring_fill(wr_ptr_d, rd_ptr_d);
  end

  // ring memory
  edrf_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (BYTE_W),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(wr_byte),
    .re_i   (mem_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(mem_rdata)
  );

  // ring control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      esc_pend_q <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      esc_pend_q <= esc_pend_d;
    end
  end

  // result slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_xfer;
    end
  end

  // result payload, read data comes straight from the memory output register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rvalid_q  <= rvalid_d;
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
      stored_q  <= stored_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_data      = rvalid_q ? mem_rdata : '0;
  assign out_o.read_valid     = rvalid_q;
  assign out_o.fill_count     = fill_q;
  assign out_o.oldest_dropped = dropped_q;
  assign out_o.byte_stored    = stored_q;

  // checks
  a_drop_needs_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.oldest_dropped |-> out_o.byte_stored && !out_o.read_valid)
    else $error("drop reported without a store");

  a_store_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> wr_ptr_q != rd_ptr_q)
    else $error("ring empty after a store");

  a_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> rd_ptr_q != $past(rd_ptr_q) && wr_ptr_q == $past(wr_ptr_q))
    else $error("pop did not move only the read pointer");

  a_swallow_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.func == FUNC_LINE && !mem_we |=> esc_pend_q && !stored_q)
    else $error("swallowed escape byte not tracked");

endmodule
`default_nettype wire
